@@ design/pli_pkg.sv @@
// Shared widths, codes and defaults of the piecewise linear interpolator.
package pli_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned IDX_W          = 6;
  localparam int unsigned CODE_W         = 2;
  localparam int unsigned COUNT_W        = 7;
  localparam int unsigned ADDR_W         = 3;
  localparam int unsigned MAX_POINTS_DEF = 64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [CODE_W-1:0] CLAMP_NONE  = 2'd0;
  localparam logic [CODE_W-1:0] CLAMP_FIRST = 2'd1;
  localparam logic [CODE_W-1:0] CLAMP_LAST  = 2'd2;

  // Register index as decoded from paddr[2].
  localparam logic REG_POINT_COUNT = 1'b0;

endpackage

@@ design/pli_if.sv @@
// Input and result channels of the piecewise linear interpolator.
interface pli_in_if import pli_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [IDX_W-1:0]         entry_index;
  logic signed [DATA_W-1:0] entry_x;
  logic signed [DATA_W-1:0] entry_y;
  logic signed [DATA_W-1:0] query_x;

  modport source (output valid, opcode, entry_index, entry_x, entry_y, query_x,
                  input ready);
  modport sink (input valid, opcode, entry_index, entry_x, entry_y, query_x,
                output ready);
endinterface

interface pli_out_if import pli_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_y;
  logic [CODE_W-1:0]        clamp_code;

  modport source (output valid, result_y, clamp_code, input ready);
  modport sink (input valid, result_y, clamp_code, output ready);
endinterface

@@ design/piecewise_linear_interpolator.sv @@
// Clamped 1-D piecewise linear interpolator over a table of Q16.16 breakpoints.
//
// A write item stores one (x, y) breakpoint. An evaluate item compares the
// query first with the first breakpoint and then with the last, and clamps if
// it lies at or beyond either end; otherwise a search walks the table memory's
// single read port one entry per cycle, and after a single 32x32 multiply a
// restoring divider yields one quotient bit per cycle. The block takes no new
// item while an evaluation runs; a finished result sits in an output register
// until taken, so the next item can be accepted meanwhile. point_count is
// written through the APB port at byte address 0; a count of zero acts as one
// and a count above MAX_POINTS acts as MAX_POINTS. Table entries hold no reset
// value.
module piecewise_linear_interpolator import pli_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pli_in_if.sink             in_ch,
  pli_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned EW = (IW > IDX_W) ? IW : IDX_W;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_FIRST = 9'b000000010,
    ST_LAST  = 9'b000000100,
    ST_SCAN  = 9'b000001000,
    ST_MUL   = 9'b000010000,
    ST_DIV   = 9'b000100000,
    ST_SUM   = 9'b001000000,
    ST_ADJ   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [COUNT_W-1:0]       point_count_q;
  logic signed [DATA_W-1:0] x_mem [MAX_POINTS];
  logic signed [DATA_W-1:0] y_mem [MAX_POINTS];
  logic signed [DATA_W-1:0] rd_x_q, rd_y_q;
  logic [IW-1:0]            raddr;
  logic [IW-1:0]            last_idx;
  logic [IW-1:0]            i_q;
  logic signed [DATA_W-1:0] q_q, xlo_q, ylo_q;
  logic [DATA_W-1:0]        dx_q, dq_q, mag_q;
  logic                     neg_q;
  logic [2*DATA_W-1:0]      acc_q;
  logic [4:0]               step_q;
  logic signed [DATA_W+1:0] sum_q;
  logic                     rem_nz_q;
  logic signed [DATA_W-1:0] res_y_q;
  logic [CODE_W-1:0]        res_code_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_y_q;
  logic [CODE_W-1:0]        out_code_q;

  logic in_acc, wr_en, eval_acc, cfg_wr, slot_free, scan_hit;
  logic [EW-1:0]            widx;
  logic [31:0]              cnt_ext;
  logic [DATA_W:0]          div_t, div_sub, div_n;
  logic                     div_ge;
  logic signed [DATA_W:0]   dx_full, dq_full;

  assign pready       = 1'b1;
  assign prdata       = (paddr[2] == REG_POINT_COUNT) ? {25'd0, point_count_q} : 32'd0;
  assign cfg_wr       = psel & penable & pwrite & pready;

  assign in_ch.ready  = (state_q == ST_IDLE);
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign widx         = EW'(in_ch.entry_index);
  assign wr_en        = in_acc && (in_ch.opcode == OP_WRITE) &&
                        ({26'd0, in_ch.entry_index} < 32'(MAX_POINTS));
  assign eval_acc     = in_acc && (in_ch.opcode == OP_EVAL);

  assign out_ch.valid      = out_valid_q;
  assign out_ch.result_y   = out_y_q;
  assign out_ch.clamp_code = out_code_q;
  assign slot_free         = !out_valid_q || out_ch.ready;

  // Index of the last breakpoint in use, with the count clamped to [1, MAX].
  assign cnt_ext = {25'd0, point_count_q};
  always_comb begin
    if (cnt_ext == 32'd0) begin
      last_idx = '0;
    end else if (cnt_ext > 32'(MAX_POINTS)) begin
      last_idx = IW'(MAX_POINTS - 1);
    end else begin
      last_idx = IW'(cnt_ext - 32'd1);
    end
  end

  always_comb begin
    case (state_q)
      ST_FIRST: raddr = last_idx;
      ST_LAST:  raddr = IW'(1);
      ST_SCAN:  raddr = i_q + IW'(1);
      default:  raddr = '0;
    endcase
  end

  assign scan_hit = (i_q == last_idx) || (rd_x_q >= q_q);
  assign dx_full  = {rd_x_q[DATA_W-1], rd_x_q} - {xlo_q[DATA_W-1], xlo_q};
  assign dq_full  = {q_q[DATA_W-1], q_q} - {xlo_q[DATA_W-1], xlo_q};

  // One restoring divide step: the partial remainder always stays below dx.
  assign div_t   = acc_q[2*DATA_W-1:DATA_W-1];
  assign div_ge  = div_t >= {1'b0, dx_q};
  assign div_sub = div_t - {1'b0, dx_q};
  assign div_n   = div_ge ? div_sub : div_t;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (eval_acc) state_d = ST_FIRST;
      ST_FIRST: state_d = (q_q <= rd_x_q) ? ST_DONE : ST_LAST;
      ST_LAST:  state_d = (q_q >= rd_x_q) ? ST_DONE : ST_SCAN;
      ST_SCAN:  if (scan_hit) state_d = ST_MUL;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV:   if (step_q == 5'd31) state_d = ST_SUM;
      ST_SUM:   state_d = ST_ADJ;
      ST_ADJ:   state_d = ST_DONE;
      ST_DONE:  if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      point_count_q <= COUNT_W'(1);
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr && (paddr[2] == REG_POINT_COUNT)) begin
        point_count_q <= pwdata[COUNT_W-1:0];
      end
      if (state_q == ST_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      x_mem[widx[IW-1:0]] <= in_ch.entry_x;
      y_mem[widx[IW-1:0]] <= in_ch.entry_y;
    end
    rd_x_q <= x_mem[raddr];
    rd_y_q <= y_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        q_q <= in_ch.query_x;
      end
      ST_FIRST: begin
        xlo_q      <= rd_x_q;
        ylo_q      <= rd_y_q;
        res_y_q    <= rd_y_q;
        res_code_q <= CLAMP_FIRST;
      end
      ST_LAST: begin
        res_y_q    <= rd_y_q;
        res_code_q <= CLAMP_LAST;
        i_q        <= IW'(1);
      end
      ST_SCAN: begin
        if (scan_hit) begin
          dx_q  <= dx_full[DATA_W-1:0];
          dq_q  <= dq_full[DATA_W-1:0];
          neg_q <= rd_y_q < ylo_q;
          mag_q <= (rd_y_q < ylo_q) ? DATA_W'(ylo_q - rd_y_q) : DATA_W'(rd_y_q - ylo_q);
        end else begin
          xlo_q <= rd_x_q;
          ylo_q <= rd_y_q;
          i_q   <= i_q + IW'(1);
        end
      end
      ST_MUL: begin
        acc_q  <= mag_q * dq_q;
        step_q <= '0;
      end
      ST_DIV: begin
        acc_q  <= {div_n[DATA_W-1:0], acc_q[DATA_W-2:0], div_ge};
        step_q <= step_q + 5'd1;
      end
      ST_SUM: begin
        sum_q    <= neg_q ? ({{2{ylo_q[DATA_W-1]}}, ylo_q} - {2'b00, acc_q[DATA_W-1:0]})
                          : ({{2{ylo_q[DATA_W-1]}}, ylo_q} + {2'b00, acc_q[DATA_W-1:0]});
        rem_nz_q <= acc_q[2*DATA_W-1:DATA_W] != '0;
      end
      ST_ADJ: begin
        // Truncation toward zero when the quotient carried a remainder.
        res_code_q <= CLAMP_NONE;
        if (rem_nz_q && neg_q && (sum_q > 0)) begin
          res_y_q <= DATA_W'(sum_q - 1);
        end else if (rem_nz_q && !neg_q && (sum_q < 0)) begin
          res_y_q <= DATA_W'(sum_q + 1);
        end else begin
          res_y_q <= sum_q[DATA_W-1:0];
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_y_q    <= res_y_q;
          out_code_q <= res_code_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ test/piecewise_linear_interpolator_tb.sv @@
// Self-checking testbench for the piecewise linear interpolator.
`timescale 1ns / 1ps

module piecewise_linear_interpolator_tb;
  import pli_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int IDLE_PCT      = 22;
  localparam int CALM_FIRST    = 900;
  localparam int CALM_LAST     = 1200;
  localparam int HOLD_AFTER    = 500;
  localparam int HOLD_CYCLES   = 800;
  localparam int SETTLE_CYCLES = 128;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int MAX_REPORTS   = 10;
  localparam int NPTS          = MAX_POINTS_DEF;

  typedef logic signed [DATA_W-1:0] q16_t;

  localparam q16_t   Q_MIN  = q16_t'(32'h8000_0000);
  localparam q16_t   Q_MAX  = q16_t'(32'h7fff_ffff);
  localparam longint X_LO   = -64'sd2147483648;
  localparam longint X_HI   = 64'sd2147483647;
  localparam longint X_SPAN = 64'sd4294967295;

  localparam logic [ADDR_W-1:0] COUNT_ADDR = {REG_POINT_COUNT, 2'b00};

  typedef enum int {SHAPE_TIGHT, SHAPE_UNIT, SHAPE_WIDE, SHAPE_SCRAMBLED} table_shape_e;

  typedef struct {
    logic             opcode;
    logic [IDX_W-1:0] index;
    q16_t             x;
    q16_t             y;
    q16_t             q;
  } pli_item_t;

  typedef struct {
    q16_t              y;
    logic [CODE_W-1:0] code;
  } pli_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  pli_in_if  in_ch ();
  pli_out_if out_ch ();

  piecewise_linear_interpolator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pli_item_t   pending_items [$];
  pli_result_t awaited_results [$];
  pli_item_t   item_on_bus;

  // Table and count as the block should hold them, the table updated on accepted items.
  q16_t               tbl_x [NPTS];
  q16_t               tbl_y [NPTS];
  logic [COUNT_W-1:0] tbl_count;

  // Table as the stimulus generator has laid it out so far.
  q16_t plan_x [NPTS];
  bit   plan_written [NPTS];
  int   plan_n;

  int unsigned cycle_count;
  int unsigned queued_items;
  int unsigned accepted_items;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned code_seen [3];
  int unsigned hold_left;
  bit          hold_armed = 1'b1;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR: %s", msg);
    end
  endfunction

  function automatic void append_item(pli_item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic void append_result(pli_result_t res);
    awaited_results = {awaited_results, res};
  endfunction

  function automatic int effective_points(logic [COUNT_W-1:0] count);
    if (count == 0) return 1;
    if (count > NPTS) return NPTS;
    return int'(count);
  endfunction

  // Exact (y_hi - y_lo) * (q - x_lo) / (x_hi - x_lo) added to y_lo, truncated toward zero.
  function automatic q16_t interp_segment(q16_t x_lo, q16_t y_lo, q16_t x_hi, q16_t y_hi,
                                          q16_t q);
    longint      dy;
    longint      total;
    logic [63:0] run;
    logic [63:0] span;
    logic [63:0] rise;
    logic [63:0] prod;
    logic [63:0] quot;
    bit          falling;
    bit          inexact;
    dy      = longint'(y_hi) - longint'(y_lo);
    run     = longint'(q) - longint'(x_lo);
    span    = longint'(x_hi) - longint'(x_lo);
    falling = dy < 0;
    rise    = falling ? -dy : dy;
    prod    = rise * run;
    quot    = prod / span;
    inexact = (prod % span) != 0;
    total   = falling ? longint'(y_lo) - longint'(quot) : longint'(y_lo) + longint'(quot);
    // A truncated quotient that pushed the sum across zero has to come back by one.
    if (inexact && falling && total > 0) begin
      total--;
    end else if (inexact && !falling && total < 0) begin
      total++;
    end
    return q16_t'(total[31:0]);
  endfunction

  function automatic pli_result_t evaluate_query(q16_t q);
    pli_result_t res;
    int          n;
    int          i;
    n = effective_points(tbl_count);
    if (q <= tbl_x[0]) begin
      res.y    = tbl_y[0];
      res.code = CLAMP_FIRST;
    end else if (q >= tbl_x[n-1]) begin
      res.y    = tbl_y[n-1];
      res.code = CLAMP_LAST;
    end else begin
      i = 1;
      while (i < n - 1 && tbl_x[i] < q) i++;
      res.y    = interp_segment(tbl_x[i-1], tbl_y[i-1], tbl_x[i], tbl_y[i], q);
      res.code = CLAMP_NONE;
    end
    return res;
  endfunction

  function automatic void absorb_item(pli_item_t it);
    if (it.opcode == OP_WRITE) begin
      tbl_x[it.index] = it.x;
      tbl_y[it.index] = it.y;
    end else begin
      append_result(evaluate_query(it.q));
    end
  endfunction

  function automatic void check_result(q16_t y, logic [CODE_W-1:0] code);
    pli_result_t want;
    if (awaited_results.size() == 0) begin
      flag_error($sformatf("unexpected result y=%0d code=%0d", y, code));
    end else begin
      want = awaited_results.pop_front();
      results_seen++;
      if (code <= CLAMP_LAST) code_seen[code]++;
      if (y !== want.y || code !== want.code) begin
        flag_error($sformatf("result %0d: expected y=%0d code=%0d, got y=%0d code=%0d",
                             results_seen, want.y, want.code, y, code));
      end
    end
  endfunction

  function automatic void queue_write(int idx, q16_t x, q16_t y);
    pli_item_t it;
    it.opcode = OP_WRITE;
    it.index  = IDX_W'(idx);
    it.x      = x;
    it.y      = y;
    it.q      = q16_t'($urandom);
    append_item(it);
    queued_items++;
    plan_x[idx]       = x;
    plan_written[idx] = 1'b1;
  endfunction

  function automatic void queue_eval(q16_t q);
    pli_item_t it;
    // Never evaluate over a table entry that holds nothing yet.
    for (int k = 0; k < plan_n; k++) begin
      if (!plan_written[k]) queue_write(k, q16_t'(X_LO + k), '0);
    end
    it.opcode = OP_EVAL;
    it.index  = IDX_W'($urandom);
    it.x      = q16_t'($urandom);
    it.y      = q16_t'($urandom);
    it.q      = q;
    append_item(it);
    queued_items++;
  endfunction

  function automatic void load_table(int n, table_shape_e shape);
    q16_t   xs [NPTS];
    q16_t   ys [NPTS];
    longint seg;
    longint xv;
    int     y_style;
    bit     downward;
    seg      = (n > 1) ? X_SPAN / (n - 1) : 1;
    y_style  = $urandom_range(3);
    downward = $urandom_range(1);
    xv       = longint'($urandom_range(2_000_000)) - 1_000_000;
    for (int k = 0; k < n; k++) begin
      case (shape)
        SHAPE_WIDE: begin
          xv = X_LO + k * seg + ((k == 0) ? 0 : longint'($urandom_range(32'(seg / 2))));
          if (k == n - 1 && n > 1 && $urandom_range(1) == 1) xv = X_HI;
        end
        SHAPE_UNIT:  if (k != 0) xv += $urandom_range(2, 1);
        SHAPE_TIGHT: if (k != 0) xv += $urandom_range(400_000, 1);
        default:     xv = $signed($urandom);
      endcase
      xs[k] = q16_t'(xv);
      case (y_style)
        0:       ys[k] = q16_t'($urandom);
        1:       ys[k] = k[0] ? Q_MAX : Q_MIN;
        default: ys[k] = q16_t'(longint'($urandom_range(2_000_000)) - 1_000_000);
      endcase
    end
    for (int k = 0; k < n; k++) begin
      int idx = downward ? n - 1 - k : k;
      queue_write(idx, xs[idx], ys[idx]);
    end
  endfunction

  function automatic q16_t pick_query();
    int     j;
    longint gap;
    case ($urandom_range(19))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2, 3:    return q16_t'($urandom);
      4:       return plan_x[0] - 1;
      5:       return plan_x[0];
      6:       return plan_x[plan_n-1];
      7:       return plan_x[plan_n-1] + 1;
      8, 9:    return plan_x[$urandom_range(plan_n - 1)];
      default: begin
        if (plan_n < 2) return q16_t'($urandom);
        j   = $urandom_range(plan_n - 1, 1);
        gap = longint'(plan_x[j]) - longint'(plan_x[j-1]);
        if (gap < 2) return plan_x[j];
        return q16_t'(longint'(plan_x[j-1]) + 1 + longint'($urandom_range(32'(gap - 2))));
      end
    endcase
  endfunction

  // Mostly evaluations, some rewrites that keep x increasing, and a little noise.
  function automatic void queue_phase_traffic(int count);
    int     idx;
    longint lo;
    longint hi;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(19))
        0: queue_write($urandom_range(NPTS - 1), q16_t'($urandom), q16_t'($urandom));
        1, 2: begin
          idx = $urandom_range(plan_n - 1);
          lo  = (idx > 0) ? longint'(plan_x[idx-1]) + 1 : X_LO;
          hi  = (idx < plan_n - 1) ? longint'(plan_x[idx+1]) - 1 : X_HI;
          if (lo <= hi) begin
            queue_write(idx, q16_t'(lo + longint'($urandom_range(32'(hi - lo)))),
                        q16_t'($urandom));
          end else begin
            queue_eval(pick_query());
          end
        end
        default: queue_eval(pick_query());
      endcase
    end
  endfunction

  task automatic set_point_count(logic [COUNT_W-1:0] value);
    logic [31:0] readback;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COUNT_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tbl_count = value;
    plan_n    = effective_points(value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[COUNT_W-1:0] !== value) begin
      flag_error($sformatf("point_count read back %0d, wrote %0d", readback[COUNT_W-1:0],
                           value));
    end
  endtask

  task automatic drain();
    while (accepted_items != queued_items || awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Input side: hold an offered item until it is taken, then maybe idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accepted_items++;
        absorb_item(item_on_bus);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 &&
            ((accepted_items >= CALM_FIRST && accepted_items < CALM_LAST) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          item_on_bus = pending_items.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.opcode      <= item_on_bus.opcode;
          in_ch.entry_index <= item_on_bus.index;
          in_ch.entry_x     <= item_on_bus.x;
          in_ch.entry_y     <= item_on_bus.y;
          in_ch.query_x     <= item_on_bus.q;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result(out_ch.result_y, out_ch.clamp_code);
      out_ch.ready <= (hold_left == 0) &&
                      ((accepted_items >= CALM_FIRST && accepted_items < CALM_LAST) ||
                       $urandom_range(99) >= IDLE_PCT);
    end
  end

  // One long back-pressure stretch, so the block fills and stops taking items.
  always @(posedge clk_i) begin
    if (hold_armed && accepted_items >= HOLD_AFTER) begin
      hold_armed <= 1'b0;
      hold_left  <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               awaited_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [COUNT_W-1:0] count_plan [8];
    logic [COUNT_W-1:0] count_value;
    table_shape_e       shape;
    int                 phase;
    int unsigned        random_start;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_WRITE;
    in_ch.entry_index = '0;
    in_ch.entry_x     = '0;
    in_ch.entry_y     = '0;
    in_ch.query_x     = '0;
    out_ch.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    tbl_count         = 7'd1;
    plan_n            = 1;
    rst_ni            = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The reset count is one: a single point clamps on either side of x_0.
    queue_write(0, '0, Q_MAX);
    queue_eval(Q_MIN);
    queue_eval('0);
    queue_eval(Q_MAX);
    drain();
    // A count of zero behaves as one.
    set_point_count(7'd0);
    queue_eval(-1);
    queue_eval(5);
    drain();

    // Two points spanning the whole range, rising and then falling.
    set_point_count(7'd2);
    queue_write(0, Q_MIN, Q_MIN);
    queue_write(1, Q_MAX, Q_MAX);
    queue_eval(Q_MIN);
    queue_eval(Q_MIN + 1);
    queue_eval('0);
    queue_eval(Q_MAX - 1);
    queue_eval(Q_MAX);
    queue_write(0, Q_MIN, Q_MAX);
    queue_write(1, Q_MAX, Q_MIN);
    queue_eval(-1);
    queue_eval(Q_MAX - 1);
    drain();

    // Three points: a query on an inner breakpoint, then x no longer increasing.
    set_point_count(7'd3);
    queue_write(0, '0, 100 << 16);
    queue_write(1, 10 << 16, -(50 << 16));
    queue_write(2, 20 << 16, 7);
    queue_eval(10 << 16);
    queue_eval((15 << 16) + 1);
    queue_write(2, 5 << 16, Q_MAX);
    queue_eval(7 << 16);
    queue_eval(12 << 16);
    drain();

    count_plan   = '{7'd64, 7'd127, 7'd2, 7'd1, 7'd0, 7'd3, 7'd64, 7'd127};
    random_start = queued_items;
    phase        = 0;
    while (queued_items - random_start < RANDOM_ITEMS) begin
      if (phase < 8) begin
        count_value = count_plan[phase];
        shape       = table_shape_e'(phase % 4);
      end else begin
        count_value = ($urandom_range(1) == 1) ? COUNT_W'($urandom_range(12, 2))
                                               : COUNT_W'($urandom_range(127));
        case ($urandom_range(7))
          0:       shape = SHAPE_SCRAMBLED;
          1, 2:    shape = SHAPE_UNIT;
          3, 4:    shape = SHAPE_WIDE;
          default: shape = SHAPE_TIGHT;
        endcase
      end
      set_point_count(count_value);
      load_table(plan_n, shape);
      queue_phase_traffic($urandom_range(120, 60));
      drain();
      phase++;
    end

    $display("Ran %0d items over %0d table settings and %0d cycles, point counts 0 to 127.",
             accepted_items, phase + 4, cycle_count);
    $display("Checked %0d results: %0d inside, %0d clamped low, %0d clamped high; %0d errors.",
             results_seen, code_seen[0], code_seen[1], code_seen[2], error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
